// File: sv/u8ql_pkg.sv
package u8ql_pkg;

  localparam int CODE_SPACE_DEF = 256;
  localparam int ATLAS_MAX_DEF  = 4096;

  localparam int AccW = 21;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_TEXT    = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    REG_FONT_SIZE    = 2'd0,
    REG_LINE_SPACING = 2'd1,
    REG_CHAR_SPACING = 2'd2,
    REG_LINE_HEIGHT  = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    EV_NONE,
    EV_RESTART,
    EV_NEWLINE,
    EV_SPACE,
    EV_TAB,
    EV_GLYPH
  } ev_kind_t;

  localparam logic [AccW-1:0] CH_TAB     = AccW'(9);
  localparam logic [AccW-1:0] CH_NEWLINE = AccW'(10);
  localparam logic [AccW-1:0] CH_SPACE   = AccW'(32);

  localparam logic [7:0] CONT_MASK  = 8'b0011_1111;
  localparam logic [7:0] LEAD4_MASK = 8'b0000_0111;
  localparam logic [7:0] CONT_TAG   = 8'b1100_0000;

  localparam logic [2:0] CORNER_LAST = 3'd5;

  localparam logic [7:0] FONT_SIZE_RST    = 8'd16;
  localparam logic [7:0] LINE_SPACING_RST = 8'd0;
  localparam logic [7:0] CHAR_SPACING_RST = 8'd0;
  localparam logic [8:0] LINE_HEIGHT_RST  = 9'd16;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  text_byte;
    logic [7:0]  glyph_code;
    logic [7:0]  glyph_width;
    logic [7:0]  glyph_height;
    logic [8:0]  glyph_bearing_x;
    logic [7:0]  glyph_advance;
    logic [11:0] atlas_x;
    logic [11:0] atlas_y;
  } in_t;

  typedef struct packed {
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [12:0] tex_u;
    logic [12:0] tex_v;
    logic [2:0]  corner_index;
    logic        last;
  } out_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  w;
    logic [7:0]  h;
    logic [8:0]  bx;
    logic [7:0]  adv;
    logic [11:0] ax;
    logic [11:0] ay;
  } entry_t;

  typedef struct packed {
    logic [7:0] font_size;
    logic [7:0] line_spacing;
    logic [7:0] char_spacing;
    logic [8:0] line_height;
  } cfg_t;

  // one glyph quad, positions already saturated
  typedef struct packed {
    logic [15:0] x0;
    logic [15:0] x1;
    logic [15:0] y0;
    logic [15:0] y1;
    logic [12:0] u0;
    logic [12:0] u1;
    logic [12:0] v0;
    logic [12:0] v1;
  } quad_t;

endpackage

// File: sv/utf8_text_quad_layout.sv
// UTF-8 text to glyph quad layout.
// Input channel (in_valid/in_ready/in_data): op 0 loads a glyph table entry,
// op 1 feeds one UTF-8 text byte, op 2 restarts text (cursor and decoder to 0).
// Output channel (out_valid/out_ready/out_data): six vertex beats per visible
// glyph, corner_index 0..5, last set on corner 5.
// Registers font_size, line_spacing, char_spacing, line_height sit on the
// APB port at byte addresses 0, 4, 8, 12; write them only while idle.
// Path: a byte that completes a known glyph is registered in the cursor stage,
// then in the vertex stage, which gives its first vertex when that stage is free.
// Throughput: one beat per cycle on either side when nothing stalls. A glyph
// holds the vertex stage until its six beats are out; control characters,
// partial sequences and loads pass one per cycle while no glyph waits.
// Reset: after rst_n the glyph table is invalidated one entry per cycle,
// all CODE_SPACE entries, with in_ready low; config writes are taken meanwhile.
// Stall: when out_ready is low the current vertex holds; one more glyph
// waits in the cursor stage, and then in_ready drops.
module utf8_text_quad_layout #(
  parameter int CODE_SPACE = u8ql_pkg::CODE_SPACE_DEF,
  parameter int ATLAS_MAX  = u8ql_pkg::ATLAS_MAX_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  u8ql_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output u8ql_pkg::out_t out_data,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  localparam int IW = $clog2(CODE_SPACE);

  u8ql_pkg::cfg_t     cfg_r;
  logic               in_fire;
  logic               ev_valid;
  logic               ev_ready;
  u8ql_pkg::ev_kind_t ev_kind;
  logic [IW-1:0]      rd_addr;
  u8ql_pkg::entry_t   entry;
  logic               clr_busy;
  logic               q_valid;
  logic               q_ready;
  u8ql_pkg::quad_t    q_data;
  logic               wr_fire;
  logic [1:0]         reg_idx;

  assign in_ready = !clr_busy && ev_ready;
  assign in_fire  = in_valid && in_ready;

  assign pready  = 1'b1;
  assign wr_fire = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.font_size    <= u8ql_pkg::FONT_SIZE_RST;
      cfg_r.line_spacing <= u8ql_pkg::LINE_SPACING_RST;
      cfg_r.char_spacing <= u8ql_pkg::CHAR_SPACING_RST;
      cfg_r.line_height  <= u8ql_pkg::LINE_HEIGHT_RST;
    end else if (wr_fire) begin
      case (reg_idx)
        u8ql_pkg::REG_FONT_SIZE:    cfg_r.font_size    <= pwdata[7:0];
        u8ql_pkg::REG_LINE_SPACING: cfg_r.line_spacing <= pwdata[7:0];
        u8ql_pkg::REG_CHAR_SPACING: cfg_r.char_spacing <= pwdata[7:0];
        u8ql_pkg::REG_LINE_HEIGHT:  cfg_r.line_height  <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      u8ql_pkg::REG_FONT_SIZE:    prdata = {24'd0, cfg_r.font_size};
      u8ql_pkg::REG_LINE_SPACING: prdata = {24'd0, cfg_r.line_spacing};
      u8ql_pkg::REG_CHAR_SPACING: prdata = {24'd0, cfg_r.char_spacing};
      u8ql_pkg::REG_LINE_HEIGHT:  prdata = {23'd0, cfg_r.line_height};
      default:                    prdata = '0;
    endcase
  end

  u8ql_decode #(
    .CODE_SPACE(CODE_SPACE)
  ) u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_data (in_data),
    .ev_valid(ev_valid),
    .ev_kind (ev_kind),
    .rd_addr (rd_addr)
  );

  u8ql_glyph_mem #(
    .CODE_SPACE(CODE_SPACE),
    .ATLAS_MAX (ATLAS_MAX)
  ) u_glyph_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .ld_en   (in_fire && (in_data.op == u8ql_pkg::OP_LOAD)),
    .in_data (in_data),
    .rd_en   (ev_valid),
    .rd_addr (rd_addr),
    .rd_data (entry),
    .clr_busy(clr_busy)
  );

  u8ql_cursor u_cursor (
    .clk     (clk),
    .rst_n   (rst_n),
    .ev_valid(ev_valid),
    .ev_kind (ev_kind),
    .ev_ready(ev_ready),
    .entry   (entry),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_data)
  );

  u8ql_vertex u_vertex (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// File: sv/u8ql_decode.sv
module u8ql_decode #(
  parameter int CODE_SPACE = u8ql_pkg::CODE_SPACE_DEF,
  localparam int IW = $clog2(CODE_SPACE)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  u8ql_pkg::in_t      in_data,
  output logic               ev_valid,
  output u8ql_pkg::ev_kind_t ev_kind,
  output logic [IW-1:0]      rd_addr
);

  logic [u8ql_pkg::AccW-1:0] acc_r, acc_nxt;
  logic [1:0]                rem_r, rem_nxt;
  logic [u8ql_pkg::AccW-1:0] code;
  logic [u8ql_pkg::AccW-1:0] acc_sh;
  logic                      have_code;
  logic                      restart;
  logic [7:0]                b;

  assign b      = in_data.text_byte;
  assign acc_sh = {acc_r[u8ql_pkg::AccW-7:0], b[5:0] & u8ql_pkg::CONT_MASK[5:0]};

  always_comb begin
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    code      = '0;
    have_code = 1'b0;
    restart   = 1'b0;
    if (in_fire) begin
      case (in_data.op)
        u8ql_pkg::OP_RESTART: begin
          acc_nxt = '0;
          rem_nxt = 2'd0;
          restart = 1'b1;
        end
        u8ql_pkg::OP_TEXT: begin
          if (!b[7]) begin
            acc_nxt   = '0;
            rem_nxt   = 2'd0;
            code      = u8ql_pkg::AccW'(b);
            have_code = 1'b1;
          end else if ((b & u8ql_pkg::CONT_TAG) == 8'b1000_0000) begin
            // stray continuation bytes fall through untouched
            if (rem_r != 2'd0) begin
              rem_nxt = rem_r - 2'd1;
              if (rem_r == 2'd1) begin
                code      = acc_sh;
                have_code = 1'b1;
                acc_nxt   = '0;
              end else begin
                acc_nxt = acc_sh;
              end
            end
          end else if (b[7:5] == 3'b110) begin
            acc_nxt = u8ql_pkg::AccW'(b[4:0]);
            rem_nxt = 2'd1;
          end else if (b[7:4] == 4'b1110) begin
            acc_nxt = u8ql_pkg::AccW'(b[3:0]);
            rem_nxt = 2'd2;
          end else if (b[7:3] == 5'b11110) begin
            acc_nxt = u8ql_pkg::AccW'(b & u8ql_pkg::LEAD4_MASK);
            rem_nxt = 2'd3;
          end else begin
            acc_nxt = '0;
            rem_nxt = 2'd0;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    ev_kind = u8ql_pkg::EV_NONE;
    if (restart) begin
      ev_kind = u8ql_pkg::EV_RESTART;
    end else if (have_code) begin
      if (code == u8ql_pkg::CH_NEWLINE) begin
        ev_kind = u8ql_pkg::EV_NEWLINE;
      end else if (code == u8ql_pkg::CH_SPACE) begin
        ev_kind = u8ql_pkg::EV_SPACE;
      end else if (code == u8ql_pkg::CH_TAB) begin
        ev_kind = u8ql_pkg::EV_TAB;
      end else if (32'(code) < CODE_SPACE) begin
        ev_kind = u8ql_pkg::EV_GLYPH;
      end
    end
  end

  assign ev_valid = (ev_kind != u8ql_pkg::EV_NONE);
  assign rd_addr  = code[IW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      rem_r <= 2'd0;
    end else begin
      acc_r <= acc_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

// File: sv/u8ql_glyph_mem.sv
module u8ql_glyph_mem #(
  parameter int CODE_SPACE = u8ql_pkg::CODE_SPACE_DEF,
  parameter int ATLAS_MAX  = u8ql_pkg::ATLAS_MAX_DEF,
  localparam int IW = $clog2(CODE_SPACE)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                ld_en,
  input  u8ql_pkg::in_t       in_data,
  input  logic                rd_en,
  input  logic [IW-1:0]       rd_addr,
  output u8ql_pkg::entry_t    rd_data,
  output logic                clr_busy
);

  localparam logic [11:0] AtlasMask  = 12'(ATLAS_MAX - 1);
  localparam logic [IW-1:0] LastAddr = IW'(CODE_SPACE - 1);

  u8ql_pkg::entry_t mem [CODE_SPACE];
  u8ql_pkg::entry_t rd_data_r;
  u8ql_pkg::entry_t wr_data;
  logic [IW-1:0]    wr_addr;
  logic             wr_en;
  logic             clr_busy_r;
  logic [IW-1:0]    clr_addr_r;
  logic             ld_in_range;

  assign ld_in_range = (32'(in_data.glyph_code) < CODE_SPACE);

  always_comb begin
    if (clr_busy_r) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = '0;
    end else begin
      wr_en         = ld_en && ld_in_range;
      wr_addr       = IW'(in_data.glyph_code);
      wr_data.valid = 1'b1;
      wr_data.w     = in_data.glyph_width;
      wr_data.h     = in_data.glyph_height;
      wr_data.bx    = in_data.glyph_bearing_x;
      wr_data.adv   = in_data.glyph_advance;
      wr_data.ax    = in_data.atlas_x & AtlasMask;
      wr_data.ay    = in_data.atlas_y & AtlasMask;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // invalidate every entry once after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + IW'(1);
      if (clr_addr_r == LastAddr) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

  a_no_load_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !ld_en)
    else $error("glyph load taken during clearing pass");

endmodule

// File: sv/u8ql_cursor.sv
module u8ql_cursor (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               ev_valid,
  input  u8ql_pkg::ev_kind_t ev_kind,
  output logic               ev_ready,
  input  u8ql_pkg::entry_t   entry,
  input  u8ql_pkg::cfg_t     cfg,
  output logic               q_valid,
  input  logic               q_ready,
  output u8ql_pkg::quad_t    q_data
);

  function automatic logic [15:0] sat16(input logic signed [17:0] v);
    logic [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'h7FFF;
    end else if (v < -18'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  logic                b_valid_r;
  u8ql_pkg::ev_kind_t  b_kind_r;
  logic [15:0]         cx_r, cx_nxt;
  logic [15:0]         cy_r, cy_nxt;
  logic                is_glyph;
  logic                b_done;

  logic signed [17:0] cx_w, cy_w, bx_w, w_w, h_w, lh_w, adv_w, fs_w, ls_w, cs_w;
  logic signed [17:0] step_w, x0_w, x1_w, y0_w, y1_w;

  assign cx_w  = $signed({{2{cx_r[15]}}, cx_r});
  assign cy_w  = $signed({{2{cy_r[15]}}, cy_r});
  assign bx_w  = $signed({{9{entry.bx[8]}}, entry.bx});
  assign w_w   = $signed({10'd0, entry.w});
  assign h_w   = $signed({10'd0, entry.h});
  assign adv_w = $signed({10'd0, entry.adv});
  assign lh_w  = $signed({9'd0, cfg.line_height});
  assign fs_w  = $signed({10'd0, cfg.font_size});
  assign ls_w  = $signed({{10{cfg.line_spacing[7]}}, cfg.line_spacing});
  assign cs_w  = $signed({{10{cfg.char_spacing[7]}}, cfg.char_spacing});

  assign step_w = fs_w + cs_w;
  assign x0_w   = cx_w + bx_w;
  assign x1_w   = x0_w + w_w;
  assign y1_w   = cy_w + lh_w;
  assign y0_w   = y1_w - h_w;

  assign q_data.x0 = sat16(x0_w);
  assign q_data.x1 = sat16(x1_w);
  assign q_data.y0 = sat16(y0_w);
  assign q_data.y1 = sat16(y1_w);
  assign q_data.u0 = {1'b0, entry.ax};
  assign q_data.u1 = 13'({1'b0, entry.ax} + {5'd0, entry.w});
  assign q_data.v0 = {1'b0, entry.ay};
  assign q_data.v1 = 13'({1'b0, entry.ay} + {5'd0, entry.h});

  // glyphs without a loaded entry retire with no effect
  assign is_glyph = (b_kind_r == u8ql_pkg::EV_GLYPH) && entry.valid;
  assign q_valid  = b_valid_r && is_glyph;
  assign b_done   = b_valid_r && (!is_glyph || q_ready);
  assign ev_ready = !b_valid_r || b_done;

  always_comb begin
    cx_nxt = cx_r;
    cy_nxt = cy_r;
    if (b_done) begin
      case (b_kind_r)
        u8ql_pkg::EV_RESTART: begin
          cx_nxt = '0;
          cy_nxt = '0;
        end
        u8ql_pkg::EV_NEWLINE: begin
          cx_nxt = '0;
          cy_nxt = sat16(cy_w + fs_w + ls_w);
        end
        u8ql_pkg::EV_SPACE: cx_nxt = sat16(cx_w + step_w);
        u8ql_pkg::EV_TAB:   cx_nxt = sat16(cx_w + (step_w <<< 2));
        u8ql_pkg::EV_GLYPH: begin
          if (entry.valid) begin
            cx_nxt = sat16(cx_w + adv_w + cs_w);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      b_kind_r  <= u8ql_pkg::EV_NONE;
      cx_r      <= '0;
      cy_r      <= '0;
    end else begin
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
      if (ev_valid && ev_ready) begin
        b_valid_r <= 1'b1;
        b_kind_r  <= ev_kind;
      end else if (b_done) begin
        b_valid_r <= 1'b0;
      end
    end
  end

  a_ctrl_never_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && b_kind_r != u8ql_pkg::EV_GLYPH) |-> ev_ready)
    else $error("control event stalled the cursor stage");

endmodule

// File: sv/u8ql_vertex.sv
module u8ql_vertex (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_ready,
  input  u8ql_pkg::quad_t q_data,
  output logic            out_valid,
  input  logic            out_ready,
  output u8ql_pkg::out_t  out_data
);

  u8ql_pkg::quad_t quad_r;
  logic [2:0]      idx_r;
  logic            v_valid_r;
  logic            out_fire;
  logic            at_last;
  logic            sel_hi_x;
  logic            sel_lo_y;

  assign out_fire = v_valid_r && out_ready;
  assign at_last  = (idx_r == u8ql_pkg::CORNER_LAST);
  assign q_ready  = !v_valid_r || (out_fire && at_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_valid_r <= 1'b0;
      idx_r     <= '0;
    end else begin
      if (q_valid && q_ready) begin
        v_valid_r <= 1'b1;
        idx_r     <= '0;
      end else if (out_fire) begin
        if (at_last) begin
          v_valid_r <= 1'b0;
        end else begin
          idx_r <= idx_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      quad_r <= q_data;
    end
  end

  // corners: (x0,y1) (x0,y0) (x1,y0) (x0,y1) (x1,y0) (x1,y1)
  always_comb begin
    sel_hi_x = idx_r inside {3'd2, 3'd4, 3'd5};
    sel_lo_y = idx_r inside {3'd1, 3'd2, 3'd4};
  end

  assign out_valid             = v_valid_r;
  assign out_data.pos_x        = sel_hi_x ? quad_r.x1 : quad_r.x0;
  assign out_data.tex_u        = sel_hi_x ? quad_r.u1 : quad_r.u0;
  assign out_data.pos_y        = sel_lo_y ? quad_r.y0 : quad_r.y1;
  assign out_data.tex_v        = sel_lo_y ? quad_r.v0 : quad_r.v1;
  assign out_data.corner_index = idx_r;
  assign out_data.last         = at_last;

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_valid_r |-> (idx_r <= u8ql_pkg::CORNER_LAST))
    else $error("corner index out of range");

  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !at_last) |=> (v_valid_r && idx_r == $past(idx_r) + 3'd1))
    else $error("corner did not advance after beat");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && at_last && !q_valid) |=> !v_valid_r)
    else $error("vertex stage kept valid after final corner");

endmodule

// File: sim/utf8_text_quad_layout_tb.sv
`timescale 1ns / 100ps

module utf8_text_quad_layout_tb;

  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 12;
  localparam int TIMEOUT_NS    = 5_000_000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  u8ql_pkg::in_t    in_data;
  logic             out_valid;
  logic             out_ready;
  u8ql_pkg::out_t   out_data;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [3:0]       paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  utf8_text_quad_layout DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // layout model state
  u8ql_pkg::entry_t          font_table [u8ql_pkg::CODE_SPACE_DEF];
  u8ql_pkg::cfg_t            layout_cfg;
  logic [15:0]               pen_x;
  logic [15:0]               pen_y;
  logic [u8ql_pkg::AccW-1:0] utf8_acc;
  logic [1:0]                utf8_left;
  u8ql_pkg::out_t            expected_vertices [$];
  logic [7:0]                known_codes [$];

  int fail_count;
  int beats_sent;
  int vertices_checked;
  int reg_writes;
  bit src_gaps;
  bit sink_stalls;
  bit hold_req;
  int src_quiet;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("utf8_text_quad_layout_tb: FAIL");
    $finish;
  end

  task automatic mismatch(string what, logic [63:0] want, logic [63:0] got);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    fail_count++;
  endtask

  function automatic logic [15:0] sat16(int v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic void reset_model();
    for (int i = 0; i < u8ql_pkg::CODE_SPACE_DEF; i++) font_table[i] = '0;
    layout_cfg = '{font_size: u8ql_pkg::FONT_SIZE_RST,
                   line_spacing: u8ql_pkg::LINE_SPACING_RST,
                   char_spacing: u8ql_pkg::CHAR_SPACING_RST,
                   line_height: u8ql_pkg::LINE_HEIGHT_RST};
    pen_x = '0;
    pen_y = '0;
    utf8_acc = '0;
    utf8_left = '0;
  endfunction

  // move the pen for one code point; known glyphs queue their six vertices
  function automatic void layout_code(logic [u8ql_pkg::AccW-1:0] code);
    int step, x0, y0, x1, y1;
    logic [12:0] u0, u1, v0, v1;
    u8ql_pkg::entry_t g;
    u8ql_pkg::out_t vx;
    bit right, low;
    step = int'(layout_cfg.font_size) + int'($signed(layout_cfg.char_spacing));
    if (code == u8ql_pkg::CH_NEWLINE) begin
      pen_x = '0;
      pen_y = sat16(int'($signed(pen_y)) + int'(layout_cfg.font_size)
                    + int'($signed(layout_cfg.line_spacing)));
    end else if (code == u8ql_pkg::CH_SPACE) begin
      pen_x = sat16(int'($signed(pen_x)) + step);
    end else if (code == u8ql_pkg::CH_TAB) begin
      pen_x = sat16(int'($signed(pen_x)) + 4 * step);
    end else if (code < u8ql_pkg::CODE_SPACE_DEF && font_table[code[7:0]].valid) begin
      g = font_table[code[7:0]];
      x0 = int'($signed(pen_x)) + int'($signed(g.bx));
      y0 = int'($signed(pen_y)) - int'(g.h) + int'(layout_cfg.line_height);
      x1 = x0 + int'(g.w);
      y1 = y0 + int'(g.h);
      u0 = 13'(g.ax);
      v0 = 13'(g.ay);
      u1 = u0 + 13'(g.w);
      v1 = v0 + 13'(g.h);
      for (int i = 0; i < 6; i++) begin
        right = (i == 2 || i == 4 || i == 5);
        low = (i == 0 || i == 3 || i == 5);
        vx.pos_x = sat16(right ? x1 : x0);
        vx.pos_y = sat16(low ? y1 : y0);
        vx.tex_u = right ? u1 : u0;
        vx.tex_v = low ? v1 : v0;
        vx.corner_index = 3'(i);
        vx.last = (vx.corner_index == u8ql_pkg::CORNER_LAST);
        expected_vertices.push_back(vx);
      end
      pen_x = sat16(int'($signed(pen_x)) + int'(g.adv)
                    + int'($signed(layout_cfg.char_spacing)));
    end
  endfunction

  function automatic void decode_text_byte(logic [7:0] b);
    logic [u8ql_pkg::AccW-1:0] code;
    casez (b)
      8'b0???????: begin
        utf8_acc = '0;
        utf8_left = '0;
        layout_code(u8ql_pkg::AccW'(b));
      end
      8'b10??????: begin
        // stray continuation is dropped
        if (utf8_left != 0) begin
          utf8_acc = {utf8_acc[u8ql_pkg::AccW-7:0], 6'(b & u8ql_pkg::CONT_MASK)};
          utf8_left--;
          if (utf8_left == 0) begin
            code = utf8_acc;
            utf8_acc = '0;
            layout_code(code);
          end
        end
      end
      8'b110?????: begin
        utf8_acc = u8ql_pkg::AccW'(b[4:0]);
        utf8_left = 2'd1;
      end
      8'b1110????: begin
        utf8_acc = u8ql_pkg::AccW'(b[3:0]);
        utf8_left = 2'd2;
      end
      8'b11110???: begin
        utf8_acc = u8ql_pkg::AccW'(b & u8ql_pkg::LEAD4_MASK);
        utf8_left = 2'd3;
      end
      default: begin
        utf8_acc = '0;
        utf8_left = '0;
      end
    endcase
  endfunction

  function automatic void predict_beat(u8ql_pkg::in_t it);
    case (it.op)
      u8ql_pkg::OP_LOAD: begin
        font_table[it.glyph_code] = '{valid: 1'b1, w: it.glyph_width, h: it.glyph_height,
                                      bx: it.glyph_bearing_x, adv: it.glyph_advance,
                                      ax: it.atlas_x & 12'(u8ql_pkg::ATLAS_MAX_DEF - 1),
                                      ay: it.atlas_y & 12'(u8ql_pkg::ATLAS_MAX_DEF - 1)};
      end
      u8ql_pkg::OP_TEXT: decode_text_byte(it.text_byte);
      u8ql_pkg::OP_RESTART: begin
        pen_x = '0;
        pen_y = '0;
        utf8_acc = '0;
        utf8_left = '0;
      end
      default: ;
    endcase
  endfunction

  function automatic u8ql_pkg::in_t any_beat();
    logic [95:0] r;
    r = {$urandom, $urandom, $urandom};
    return r[$bits(u8ql_pkg::in_t)-1:0];
  endfunction

  task automatic send_beat(u8ql_pkg::in_t it);
    if (src_quiet > 0) src_quiet--;
    else if ($urandom_range(0, 24) == 0) src_quiet = $urandom_range(8, 40);
    if (src_gaps && src_quiet == 0 && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    predict_beat(it);
    beats_sent++;
  endtask

  task automatic send_text(logic [7:0] b);
    u8ql_pkg::in_t it;
    it = any_beat();
    it.op = u8ql_pkg::OP_TEXT;
    it.text_byte = b;
    send_beat(it);
  endtask

  task automatic send_op(logic [1:0] op);
    u8ql_pkg::in_t it;
    it = any_beat();
    it.op = op;
    send_beat(it);
  endtask

  // standard UTF-8 encoding of one code point
  task automatic send_code(logic [20:0] cp);
    if (cp < 21'h80) begin
      send_text(cp[7:0]);
    end else if (cp < 21'h800) begin
      send_text({3'b110, cp[10:6]});
      send_text({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      send_text({4'b1110, cp[15:12]});
      send_text({2'b10, cp[11:6]});
      send_text({2'b10, cp[5:0]});
    end else begin
      send_text({5'b11110, cp[20:18]});
      send_text({2'b10, cp[17:12]});
      send_text({2'b10, cp[11:6]});
      send_text({2'b10, cp[5:0]});
    end
  endtask

  task automatic load_glyph(logic [7:0] code, logic [7:0] w, logic [7:0] h,
                            logic [8:0] bx, logic [7:0] adv, logic [11:0] ax,
                            logic [11:0] ay);
    u8ql_pkg::in_t it;
    it = any_beat();
    it.op = u8ql_pkg::OP_LOAD;
    it.glyph_code = code;
    it.glyph_width = w;
    it.glyph_height = h;
    it.glyph_bearing_x = bx;
    it.glyph_advance = adv;
    it.atlas_x = ax;
    it.atlas_y = ay;
    send_beat(it);
    known_codes.push_back(code);
  endtask

  task automatic load_random_glyph();
    u8ql_pkg::in_t it;
    it = any_beat();
    it.op = u8ql_pkg::OP_LOAD;
    send_beat(it);
    known_codes.push_back(it.glyph_code);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_vertices.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write, then read back
  task automatic set_reg(u8ql_pkg::reg_idx_t r, logic [31:0] value);
    logic [31:0] mask;
    mask = (r == u8ql_pkg::REG_LINE_HEIGHT) ? 32'h1ff : 32'hff;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (r)
      u8ql_pkg::REG_FONT_SIZE:    layout_cfg.font_size = value[7:0];
      u8ql_pkg::REG_LINE_SPACING: layout_cfg.line_spacing = value[7:0];
      u8ql_pkg::REG_CHAR_SPACING: layout_cfg.char_spacing = value[7:0];
      u8ql_pkg::REG_LINE_HEIGHT:  layout_cfg.line_height = value[8:0];
      default: ;
    endcase
    reg_writes++;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if ((prdata & mask) !== (value & mask)) mismatch("register readback", value & mask,
                                                     prdata & mask);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_layout(logic [7:0] fs, logic [7:0] ls, logic [7:0] cs, logic [8:0] lh);
    wait_idle();
    set_reg(u8ql_pkg::REG_FONT_SIZE, 32'(fs));
    set_reg(u8ql_pkg::REG_LINE_SPACING, {{24{ls[7]}}, ls});
    set_reg(u8ql_pkg::REG_CHAR_SPACING, {{24{cs[7]}}, cs});
    set_reg(u8ql_pkg::REG_LINE_HEIGHT, 32'(lh));
  endtask

  task automatic random_text(int count);
    int stop;
    int pick;
    logic [7:0] c;
    stop = beats_sent + count;
    while (beats_sent < stop) begin
      pick = $urandom_range(0, 99);
      c = known_codes[$urandom_range(0, known_codes.size() - 1)];
      if (pick < 50) begin
        send_code(21'(c));
      end else if (pick < 58) begin
        case ($urandom_range(0, 2))
          0: send_code(u8ql_pkg::CH_SPACE);
          1: send_code(u8ql_pkg::CH_TAB);
          default: send_code(u8ql_pkg::CH_NEWLINE);
        endcase
      end else if (pick < 63) begin
        // two-byte form, overlong when the code is below 0x80
        send_text({6'b110000, c[7:6]});
        send_text({2'b10, c[5:0]});
      end else if (pick < 68) begin
        send_code(21'($urandom_range(u8ql_pkg::CODE_SPACE_DEF, 21'h1fffff)));
      end else if (pick < 74) begin
        // lead byte left unfinished; a later lead byte, ASCII byte or restart breaks it
        send_text(8'($urandom_range(8'hc0, 8'hf7)));
      end else if (pick < 80) begin
        send_text(8'($urandom));
      end else if (pick < 84) begin
        send_op(u8ql_pkg::OP_RESTART);
      end else if (pick < 86) begin
        send_op(OP_UNUSED);
      end else if (pick < 92) begin
        load_random_glyph();
      end else begin
        send_code(21'($urandom_range(0, u8ql_pkg::CODE_SPACE_DEF - 1)));
      end
    end
  endtask

  task automatic test_directed_text();
    logic [7:0] script [$];
    script = '{8'h41, 8'h20, 8'h09, 8'h41, 8'h0a, 8'h00, 8'he2, 8'hc3, 8'ha9, 8'h80,
               8'hc3, 8'h41, 8'hf8, 8'hff, 8'he2, 8'h82, 8'hac, 8'hf0, 8'h9f, 8'h98,
               8'h80, 8'hc0, 8'h8a, 8'he0, 8'h81, 8'h81, 8'hc3, 8'hbf, 8'h5a};
    load_glyph(8'h41, 8'd10, 8'd12, 9'd1, 8'd11, 12'd0, 12'd0);
    load_glyph(8'h00, 8'd255, 8'd255, 9'h100, 8'd255, 12'hfff, 12'hfff);
    load_glyph(8'hff, 8'd0, 8'd0, 9'h0ff, 8'd0, 12'haaa, 12'h555);
    load_glyph(8'he9, 8'd7, 8'd9, 9'd0, 8'd8, 12'd100, 12'd200);
    foreach (script[i]) send_text(script[i]);
    send_op(OP_UNUSED);
    send_op(u8ql_pkg::OP_RESTART);
    send_text(8'h41);
  endtask

  // drive the pen into both saturation limits along x, then step lines
  task automatic test_cursor_saturation();
    set_layout(8'd255, 8'h7f, 8'h7f, 9'h1ff);
    send_op(u8ql_pkg::OP_RESTART);
    repeat (23) send_code(u8ql_pkg::CH_TAB);
    send_text(8'h41);
    send_text(8'h00);
    repeat (4) send_code(u8ql_pkg::CH_NEWLINE);
    send_text(8'h41);
    set_layout(8'd1, 8'h80, 8'h80, 9'd0);
    send_op(u8ql_pkg::OP_RESTART);
    repeat (66) send_code(u8ql_pkg::CH_TAB);
    send_text(8'h41);
    send_text(8'h00);
    repeat (4) send_code(u8ql_pkg::CH_NEWLINE);
    send_text(8'h41);
  endtask

  task automatic test_config_phases();
    for (int phase = 0; phase < 2; phase++) begin
      case (phase)
        0: set_layout(8'd1, 8'h80, 8'h80, 9'd0);
        default: set_layout(8'($urandom_range(1, 255)), 8'($urandom), 8'($urandom),
                            9'($urandom_range(0, 511)));
      endcase
      send_op(u8ql_pkg::OP_RESTART);
      if (phase == 0) repeat (8) load_random_glyph();
      random_text(25);
    end
  endtask

  task automatic test_backpressure();
    wait_idle();
    src_gaps = 1'b0;
    hold_req = 1'b1;
    repeat (10) send_code(21'(known_codes[$urandom_range(0, known_codes.size() - 1)]));
    while (hold_req) @(posedge clk);
    src_gaps = 1'b1;
  endtask

  task automatic test_full_rate();
    wait_idle();
    set_layout(8'($urandom_range(1, 255)), 8'($urandom), 8'($urandom),
               9'($urandom_range(0, 511)));
    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    send_op(u8ql_pkg::OP_RESTART);
    random_text(20);
  endtask

  // output pacing: random stall bursts, quiet stretches, one long hold on request
  initial begin : sink_pacing
    int quiet;
    quiet = 0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (quiet > 0) quiet--;
      else if ($urandom_range(0, 19) == 0) quiet = $urandom_range(10, 40);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
        hold_req = 1'b0;
      end else if (sink_stalls && quiet == 0 && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : vertex_check
    u8ql_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_vertices.size() == 0) begin
        $display("%0t: vertex beat with nothing expected, expected none, got %0h",
                 $time, out_data);
        fail_count++;
      end else begin
        want = expected_vertices.pop_front();
        if (out_data.pos_x !== want.pos_x) mismatch("pos_x", want.pos_x, out_data.pos_x);
        if (out_data.pos_y !== want.pos_y) mismatch("pos_y", want.pos_y, out_data.pos_y);
        if (out_data.tex_u !== want.tex_u) mismatch("tex_u", want.tex_u, out_data.tex_u);
        if (out_data.tex_v !== want.tex_v) mismatch("tex_v", want.tex_v, out_data.tex_v);
        if (out_data.corner_index !== want.corner_index)
          mismatch("corner_index", want.corner_index, out_data.corner_index);
        if (out_data.last !== want.last) mismatch("last", want.last, out_data.last);
        vertices_checked++;
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    fail_count = 0;
    beats_sent = 0;
    vertices_checked = 0;
    reg_writes = 0;
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
    hold_req = 1'b0;
    src_quiet = 0;
    reset_model();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_text();
    test_cursor_saturation();
    test_config_phases();
    test_backpressure();
    test_full_rate();
    wait_idle();

    $display("Sent %0d input beats, checked %0d vertex beats, %0d register writes.",
             beats_sent, vertices_checked, reg_writes);
    $display("Covered UTF-8 edge cases, pen saturation, extreme settings, output hold.");
    if (fail_count == 0) begin
      $display("utf8_text_quad_layout_tb: PASS");
    end else begin
      $display("utf8_text_quad_layout_tb: FAIL");
    end
    $finish;
  end

endmodule
